@@ src/brss_pkg.sv @@
// Package for the byte range segment splitter.
// Holds the word types, the plan handed to the emitter, the control states and
// the count clamp. No dependencies.
package brss_pkg;

    localparam int TOTAL_W      = 64;
    localparam int COUNT_W      = 7;
    localparam int INDEX_W      = 6;
    localparam int MAX_SEGMENTS = 64;
    localparam int MAX_RESET    = 8;

    // Input word as it arrives on the input channel.
    typedef struct packed {
        logic [TOTAL_W-1:0] total_bytes;
        logic [COUNT_W-1:0] requested_count;
        logic               range_supported;
    } t_in_word;

    // One segment result on the output channel.
    typedef struct packed {
        logic [INDEX_W-1:0] segment_index;
        logic [TOTAL_W-1:0] begin_byte;
        logic [TOTAL_W-1:0] end_byte;
        logic [TOTAL_W-1:0] segment_size;
        logic [COUNT_W-1:0] actual_count;
        logic [COUNT_W-1:0] effective_request;
        logic               ranges_used;
        logic               empty_length;
        logic               last_segment;
    } t_out_word;

    // Everything the emitter needs to walk through the segments of one item.
    typedef struct packed {
        logic [TOTAL_W-1:0] avg;
        logic [COUNT_W-1:0] rem;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] request;
        logic               ranges_used;
        logic               empty;
    } t_plan;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

    // Clamp a count into the range one to MAX_SEGMENTS.
    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v);
        logic [COUNT_W-1:0] res;
        if (v == '0) begin
            res = COUNT_W'(1);
        end else if (v > COUNT_W'(MAX_SEGMENTS)) begin
            res = COUNT_W'(MAX_SEGMENTS);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

@@ src/byte_range_segment_splitter_unit.sv @@
// Top level of the byte range segment splitter.
// Settles the segment count, then runs brss_divider and brss_emitter.
// Depends on brss_pkg, brss_divider and brss_emitter.
//
// Use:
// An input word (total length, requested count, range flag) is taken on the
// input channel when i_in_valid is high and o_in_stall is low. The block then
// divides the length by the segment count one quotient bit per cycle, and
// sends one output word per segment, one per cycle while the receiver does
// not stall. The first segment is loaded into the output register once the
// bit-serial divider is done and the emitter has taken the plan. A zero
// length goes through the same path and gives a single empty segment.
// o_in_stall stays high from acceptance until the last segment has entered
// the output register, so the next word may be taken while that last
// segment still waits. A high i_out_stall holds a valid output word and
// pauses the emitter while that word waits. max_workers is written through
// i_cfg_wr_en and i_cfg_wr_data; the user must write it only while the
// block is idle, which the block leaves unenforced. Reset, synchronous and
// active low, empties the block and sets max_workers to 8.
module byte_range_segment_splitter_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  brss_pkg::t_in_word           i_in_word,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output brss_pkg::t_out_word          o_out_word,
    input  logic                         i_cfg_wr_en,
    input  logic [brss_pkg::COUNT_W-1:0] i_cfg_wr_data
);
    import brss_pkg::*;

    t_state             r_state, n_state;
    logic [COUNT_W-1:0] r_max_workers;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] r_request;
    logic               r_ranges_used;
    logic               r_empty;

    logic               accept;
    logic [COUNT_W-1:0] req_c;
    logic [COUNT_W-1:0] max_c;
    logic [COUNT_W-1:0] limit;
    logic [COUNT_W-1:0] want;
    logic [COUNT_W-1:0] count;
    logic               div_done;
    logic [TOTAL_W-1:0] quotient;
    logic [COUNT_W-1:0] remainder;
    logic               emit_done;
    t_plan              plan;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_workers <= COUNT_W'(MAX_RESET);
        end else if (i_cfg_wr_en) begin
            r_max_workers <= i_cfg_wr_data;
        end
    end

    // Segment count: request, range support, maximum and length all limit it.
    always_comb begin
        req_c = clamp_count(i_in_word.requested_count);
        max_c = clamp_count(r_max_workers);
        if ((i_in_word.total_bytes[TOTAL_W-1:COUNT_W] == '0)
                && (i_in_word.total_bytes[COUNT_W-1:0] < max_c)) begin
            limit = i_in_word.total_bytes[COUNT_W-1:0];
        end else begin
            limit = max_c;
        end
        want  = i_in_word.range_supported ? req_c : COUNT_W'(1);
        count = (want > limit) ? limit : want;
        if (count == '0) begin
            count = COUNT_W'(1);
        end
    end

    // Per-item plan fields kept for the emitter.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_count       <= count;
            r_request     <= req_c;
            r_ranges_used <= i_in_word.range_supported && (count > COUNT_W'(1));
            r_empty       <= (i_in_word.total_bytes == '0);
        end
    end

    // Control state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: divide, then emit until the last segment is loaded.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    brss_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept),
        .i_dividend  (i_in_word.total_bytes),
        .i_divisor   (count),
        .o_done      (div_done),
        .o_quotient  (quotient),
        .o_remainder (remainder)
    );

    // Plan handed over when the quotient is ready.
    always_comb begin
        plan.avg         = quotient;
        plan.rem         = remainder;
        plan.count       = r_count;
        plan.request     = r_request;
        plan.ranges_used = r_ranges_used;
        plan.empty       = r_empty;
    end

    brss_emitter u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_done),
        .i_plan      (plan),
        .o_done      (emit_done),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

`ifndef SYNTHESIS
    // An empty item gives one empty, final segment.
    a_empty_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.empty_length
            |-> o_out_word.last_segment && (o_out_word.segment_size == '0))
        else $error("empty item word is not a single empty segment");

    // Each segment ends where its size says.
    a_end_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.empty_length
            |-> (o_out_word.end_byte
                 == o_out_word.begin_byte + o_out_word.segment_size - TOTAL_W'(1)))
        else $error("segment end does not match begin and size");

    // A segment that is not the last lies below the segment count.
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.last_segment
            |-> (({1'b0, o_out_word.segment_index} + COUNT_W'(1))
                 < o_out_word.actual_count))
        else $error("non-final segment index out of range");

    // Taking an item makes the block busy.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("block not busy after taking a word");
`endif

endmodule

@@ src/brss_divider.sv @@
// Bit-serial restoring divider: 64-bit dividend by a 7-bit divisor.
// One quotient bit per cycle through a shift register. Depends on brss_pkg.
module brss_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [brss_pkg::TOTAL_W-1:0] i_dividend,
    input  logic [brss_pkg::COUNT_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [brss_pkg::TOTAL_W-1:0] o_quotient,
    output logic [brss_pkg::COUNT_W-1:0] o_remainder
);
    import brss_pkg::*;

    localparam int CNT_W = $clog2(TOTAL_W);

    logic [TOTAL_W-1:0] r_q, n_q;
    logic [COUNT_W-1:0] r_r, n_r;
    logic [COUNT_W-1:0] r_d;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_active;
    logic               r_done;
    logic [COUNT_W-1:0] trial;
    logic               ge;

    // One step: bring down the next dividend bit and subtract where it fits.
    // The remainder stays below the divisor, which is at most 64.
    always_comb begin
        trial = {r_r[COUNT_W-2:0], r_q[TOTAL_W-1]};
        ge    = (trial >= r_d);
        n_r   = ge ? (trial - r_d) : trial;
        n_q   = {r_q[TOTAL_W-2:0], ge};
    end

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (i_start) begin
                r_active <= 1'b1;
                r_done   <= 1'b0;
                r_cnt    <= CNT_W'(TOTAL_W - 1);
            end else if (r_active) begin
                r_cnt  <= r_cnt - CNT_W'(1);
                r_done <= (r_cnt == '0);
                if (r_cnt == '0) begin
                    r_active <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    // Datapath shift registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_active) begin
            r_q <= n_q;
            r_r <= n_r;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_r;

endmodule

@@ src/brss_emitter.sv @@
// Segment emitter: walks one plan and sends a word per segment.
// Holds the output register and running begin offset. Depends on brss_pkg.
module brss_emitter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  brss_pkg::t_plan     i_plan,
    output logic                o_done,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output brss_pkg::t_out_word o_out_word
);
    import brss_pkg::*;

    t_plan              r_plan;
    logic [INDEX_W-1:0] r_idx;
    logic [TOTAL_W-1:0] r_begin;
    logic               r_active;
    logic               r_out_valid;
    t_out_word          r_out_word;
    t_out_word          n_out_word;
    logic               step;
    logic               last;
    logic [TOTAL_W-1:0] size;
    logic [TOTAL_W-1:0] end_off;

    // A segment moves into the output register when that register is free.
    assign step = r_active && (!r_out_valid || !i_out_stall);
    assign last = (({1'b0, r_idx} + COUNT_W'(1)) == r_plan.count);

    // Leading segments up to the remainder carry one extra byte.
    always_comb begin
        size    = r_plan.avg + TOTAL_W'(({1'b0, r_idx} < r_plan.rem));
        end_off = r_begin + size - TOTAL_W'(1);
        n_out_word = '0;
        n_out_word.effective_request = r_plan.request;
        n_out_word.last_segment      = last;
        n_out_word.actual_count      = r_plan.count;
        if (r_plan.empty) begin
            n_out_word.empty_length = 1'b1;
        end else begin
            n_out_word.segment_index = r_idx;
            n_out_word.begin_byte    = r_begin;
            n_out_word.end_byte      = end_off;
            n_out_word.segment_size  = size;
            n_out_word.ranges_used   = r_plan.ranges_used;
        end
    end

    // Sequencer and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_start) begin
                r_active <= 1'b1;
            end else if (step && last) begin
                r_active <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Plan, running offset and output word.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_plan  <= i_plan;
            r_idx   <= '0;
            r_begin <= '0;
        end else if (step) begin
            r_idx   <= r_idx + INDEX_W'(1);
            r_begin <= r_begin + size;
        end
        if (step) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_done      = step && last;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ tb/sv/tb_byte_range_segment_splitter_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for byte_range_segment_splitter_unit: a directed table, then random
// words under several max_workers settings, all segment words checked by table or predictor.
// Depends on brss_pkg and the unit under test only.
module tb_byte_range_segment_splitter_unit;

    import brss_pkg::*;

    localparam int          RANDOM_PHASES  = 10;
    localparam int          PHASE_WORDS    = 50;
    localparam int          IDLE_SETTLE    = 8;
    localparam int          END_SETTLE     = 140;
    localparam int          LONG_HOLD      = 600;
    localparam longint      WORST_WORD     = 70 + 150 + MAX_SEGMENTS * 81;
    localparam longint      CYCLE_LIMIT    = 4 * (RANDOM_PHASES * PHASE_WORDS + 40) * WORST_WORD
                                             + 4 * LONG_HOLD;
    localparam logic [TOTAL_W-1:0] ONES    = {TOTAL_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOP_BIT = {1'b1, {(TOTAL_W-1){1'b0}}};

    // One row of the directed table: an optional max_workers write, the input word and,
    // where it is obvious, the single segment word it must give.
    typedef struct {
        bit                 set_max;
        logic [COUNT_W-1:0] max_val;
        t_in_word           word;
        bit                 typed;
        t_out_word          want;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    t_in_word           i_in_word     = '0;
    logic               i_out_stall   = 1'b0;
    logic               i_cfg_wr_en   = 1'b0;
    logic [COUNT_W-1:0] i_cfg_wr_data = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out_word          o_out_word;

    t_out_word          segments_due[$];
    t_dir_row           directed_rows[$];
    logic [COUNT_W-1:0] max_workers_shadow = COUNT_W'(MAX_RESET);
    int unsigned        words_sent   = 0;
    int unsigned        results_seen = 0;
    int unsigned        cfg_writes   = 0;
    int unsigned        mismatches   = 0;
    int unsigned        hold_left    = 0;
    int unsigned        calm_left    = 0;
    bit                 hold_request = 1'b0;
    bit                 hold_taken   = 1'b0;

    byte_range_segment_splitter_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_word   (o_out_word),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Append one segment word to the queue of expected words.
    function automatic void expect_segment(input t_out_word seg);
        segments_due = {segments_due, seg};
    endfunction

    // Append one row to the directed table.
    function automatic void add_row(input t_dir_row row);
        directed_rows = {directed_rows, row};
    endfunction

    // Work out the segment words that one accepted input word must produce.
    function automatic void predict_segments(input t_in_word w);
        logic [COUNT_W-1:0] req;
        logic [COUNT_W-1:0] cap;
        logic [COUNT_W-1:0] n;
        logic [TOTAL_W-1:0] share;
        logic [TOTAL_W-1:0] extra;
        logic [TOTAL_W-1:0] first;
        logic [TOTAL_W-1:0] size;
        t_out_word          seg;
        int                 i;
        req = w.requested_count;
        if (req == '0) begin
            req = COUNT_W'(1);
        end else if (req > COUNT_W'(MAX_SEGMENTS)) begin
            req = COUNT_W'(MAX_SEGMENTS);
        end
        seg = '0;
        seg.effective_request = req;
        if (w.total_bytes == '0) begin
            // An empty stream still gives one segment word, flagged as empty.
            seg.actual_count = COUNT_W'(1);
            seg.empty_length = 1'b1;
            seg.last_segment = 1'b1;
            expect_segment(seg);
        end else begin
            cap = max_workers_shadow;
            if (cap == '0) begin
                cap = COUNT_W'(1);
            end else if (cap > COUNT_W'(MAX_SEGMENTS)) begin
                cap = COUNT_W'(MAX_SEGMENTS);
            end
            if (w.total_bytes < TOTAL_W'(cap)) begin
                cap = w.total_bytes[COUNT_W-1:0];
            end
            n = w.range_supported ? req : COUNT_W'(1);
            if (n > cap) begin
                n = cap;
            end
            share = w.total_bytes / TOTAL_W'(n);
            extra = w.total_bytes % TOTAL_W'(n);
            first = '0;
            // The first 'extra' segments carry one byte more than the rest.
            for (i = 0; i < int'(n); i++) begin
                size                  = share + ((TOTAL_W'(i) < extra) ? 1 : 0);
                seg.segment_index     = INDEX_W'(i);
                seg.begin_byte        = first;
                seg.end_byte          = first + size - 1;
                seg.segment_size      = size;
                seg.actual_count      = n;
                seg.ranges_used       = w.range_supported && (n > COUNT_W'(1));
                seg.last_segment      = (i == int'(n) - 1);
                expect_segment(seg);
                first = first + size;
            end
        end
    endfunction

    function automatic t_dir_row mk_row(
        input bit                 set_max,
        input logic [COUNT_W-1:0] max_val,
        input logic [TOTAL_W-1:0] total,
        input logic [COUNT_W-1:0] req,
        input bit                 ranges,
        input bit                 typed,
        input logic [TOTAL_W-1:0] lo,
        input logic [TOTAL_W-1:0] hi,
        input logic [TOTAL_W-1:0] size,
        input logic [COUNT_W-1:0] act,
        input logic [COUNT_W-1:0] eff,
        input bit                 empty
    );
        t_dir_row row;
        row.set_max                = set_max;
        row.max_val                = max_val;
        row.word.total_bytes       = total;
        row.word.requested_count   = req;
        row.word.range_supported   = ranges;
        row.typed                  = typed;
        row.want                   = '0;
        row.want.begin_byte        = lo;
        row.want.end_byte          = hi;
        row.want.segment_size      = size;
        row.want.actual_count      = act;
        row.want.effective_request = eff;
        row.want.empty_length      = empty;
        row.want.last_segment      = 1'b1;
        return row;
    endfunction

    // Random input word, weighted towards small lengths and near-limit counts.
    function automatic t_in_word random_word();
        t_in_word    w;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            w.total_bytes = '0;
        end else if (pick < 35) begin
            w.total_bytes = TOTAL_W'($urandom_range(1, 200));
        end else if (pick < 60) begin
            w.total_bytes = {$urandom, $urandom};
        end else if (pick < 80) begin
            w.total_bytes = {$urandom, $urandom} >> $urandom_range(1, 63);
        end else if (pick < 90) begin
            w.total_bytes = TOTAL_W'($urandom_range(1, 5000)) * $urandom_range(1, 64)
                            + $urandom_range(0, 2);
        end else if (pick < 95) begin
            w.total_bytes = ONES - TOTAL_W'($urandom_range(0, 3));
        end else begin
            w.total_bytes = TOP_BIT + TOTAL_W'($urandom_range(0, 3));
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            w.requested_count = '0;
        end else if (pick < 20) begin
            w.requested_count = COUNT_W'($urandom_range(MAX_SEGMENTS + 1, 127));
        end else if (pick < 30) begin
            w.requested_count = COUNT_W'(MAX_SEGMENTS);
        end else begin
            w.requested_count = COUNT_W'($urandom_range(1, MAX_SEGMENTS - 1));
        end
        w.range_supported = ($urandom_range(0, 9) < 8);
        return w;
    endfunction

    // Gap before the next word: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned pick;
        int unsigned gap;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            gap = 0;
        end else if (pick < 85) begin
            gap = $urandom_range(1, 3);
        end else if (pick < 97) begin
            gap = $urandom_range(4, 20);
        end else begin
            gap = $urandom_range(40, 150);
        end
        return gap;
    endfunction

    // Offer one word, wait for it to be taken, then record what it must produce.
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word want);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (typed) begin
            expect_segment(want);
        end else begin
            predict_segments(w);
        end
        words_sent++;
    endtask

    // Let every outstanding segment word drain, then wait out the settle time with the block idle.
    task automatic wait_drained(input int unsigned settle);
        i_in_valid <= 1'b0;
        while (segments_due.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_max_workers(input logic [COUNT_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en        <= 1'b0;
        max_workers_shadow  = value;
        cfg_writes++;
    endtask

    task automatic check_field(input string name, input logic [TOTAL_W-1:0] want,
                               input logic [TOTAL_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Receiver: random stall pattern, quiet stretches, and one long hold on request.
    always @(posedge i_clk) begin : out_stall_gen
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_request && !hold_taken) begin
            hold_taken  <= 1'b1;
            hold_left   <= LONG_HOLD - 1;
            i_out_stall <= 1'b1;
        end else if (calm_left != 0) begin
            i_out_stall <= 1'b0;
            calm_left   <= calm_left - 1;
        end else if (pick < 4) begin
            i_out_stall <= 1'b0;
            calm_left   <= $urandom_range(30, 200);
        end else if (pick < 7) begin
            i_out_stall <= 1'b1;
            hold_left   <= $urandom_range(20, 80);
        end else if (pick < 30) begin
            i_out_stall <= 1'b1;
            hold_left   <= $urandom_range(0, 2);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Compare each accepted segment word with the oldest expectation.
    always @(posedge i_clk) begin : segment_check
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen <= results_seen + 1;
            if (segments_due.size() == 0) begin
                $error("segment word with nothing expected: index %0d, begin 'h%0h",
                       o_out_word.segment_index, o_out_word.begin_byte);
                mismatches++;
            end else begin
                want = segments_due.pop_front();
                check_field("segment_index", want.segment_index, o_out_word.segment_index);
                check_field("begin_byte", want.begin_byte, o_out_word.begin_byte);
                check_field("end_byte", want.end_byte, o_out_word.end_byte);
                check_field("segment_size", want.segment_size, o_out_word.segment_size);
                check_field("actual_count", want.actual_count, o_out_word.actual_count);
                check_field("effective_request", want.effective_request,
                            o_out_word.effective_request);
                check_field("ranges_used", want.ranges_used, o_out_word.ranges_used);
                check_field("empty_length", want.empty_length, o_out_word.empty_length);
                check_field("last_segment", want.last_segment, o_out_word.last_segment);
            end
        end
    end

    // Watchdog on the total run length.
    initial begin : watchdog
        longint cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge i_clk);
        $display("tb_byte_range_segment_splitter_unit: errors");
        $finish;
    end

    initial begin : stimulus
        int          r;
        int          p;
        int          k;
        t_out_word   none;
        logic [COUNT_W-1:0] setting;
        none = '0;

        // Directed table: zero lengths, extreme lengths and counts, max_workers extremes.
        add_row(mk_row(0, 0, '0, 0, 0, 1, '0, '0, '0, 1, 1, 1));
        add_row(mk_row(0, 0, '0, 127, 1, 1, '0, '0, '0, 1, 64, 1));
        add_row(mk_row(0, 0, ONES, 64, 0, 1, '0, ONES - 1, ONES, 1, 64, 0));
        add_row(mk_row(0, 0, 64'd1, 64, 1, 1, '0, '0, 64'd1, 1, 64, 0));
        add_row(mk_row(0, 0, ONES, 64, 1, 0, '0, '0, '0, 0, 0, 0));
        add_row(mk_row(0, 0, 64'd13, 5, 1, 0, '0, '0, '0, 0, 0, 0));
        add_row(mk_row(0, 0, 64'd7, 20, 1, 0, '0, '0, '0, 0, 0, 0));
        add_row(mk_row(0, 0, 64'd100, 0, 1, 0, '0, '0, '0, 0, 0, 0));
        add_row(mk_row(0, 0, TOP_BIT, 100, 1, 0, '0, '0, '0, 0, 0, 0));
        add_row(mk_row(1, 0, 64'd1000, 64, 1, 1, '0, 64'd999, 64'd1000,
                       1, 64, 0));
        add_row(mk_row(1, 127, ONES, 127, 1, 0, '0, '0, '0, 0, 0, 0));
        add_row(mk_row(0, 0, 64'd64, 64, 1, 0, '0, '0, '0, 0, 0, 0));
        add_row(mk_row(0, 0, 64'd63, 64, 1, 0, '0, '0, '0, 0, 0, 0));
        add_row(mk_row(0, 0, 64'd200, 65, 0, 1, '0, 64'd199, 64'd200,
                       1, 64, 0));
        add_row(mk_row(1, 64, 64'd1000003, 64, 1, 0, '0, '0, '0, 0, 0, 0));
        add_row(mk_row(1, 1, ONES, 64, 1, 1, '0, ONES - 1, ONES, 1, 64, 0));
        add_row(mk_row(1, 65, 64'd12345, 70, 1, 0, '0, '0, '0, 0, 0, 0));
        add_row(mk_row(1, 8, '0, 5, 1, 1, '0, '0, '0, 1, 5, 1));
        add_row(mk_row(0, 0, 64'd2, 2, 1, 0, '0, '0, '0, 0, 0, 0));
        add_row(mk_row(0, 0, 64'd9, 8, 1, 0, '0, '0, '0, 0, 0, 0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < directed_rows.size(); r++) begin
            if (directed_rows[r].set_max) begin
                wait_drained(IDLE_SETTLE);
                write_max_workers(directed_rows[r].max_val);
            end
            send_word(directed_rows[r].word, directed_rows[r].typed, directed_rows[r].want);
        end

        // Random phases, each under its own max_workers setting; extremes come first.
        for (p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained(IDLE_SETTLE);
            case (p)
                0:       setting = '0;
                1:       setting = COUNT_W'(127);
                2:       setting = COUNT_W'(MAX_SEGMENTS);
                3:       setting = COUNT_W'(1);
                4:       setting = COUNT_W'(MAX_SEGMENTS + 1);
                default: setting = COUNT_W'($urandom_range(0, 127));
            endcase
            write_max_workers(setting);
            for (k = 0; k < PHASE_WORDS; k++) begin
                // Hold the output back for a long stretch while words keep coming.
                if (p == 2 && k == 10) begin
                    hold_request <= 1'b1;
                end
                send_word(random_word(), 1'b0, none);
            end
        end

        wait_drained(END_SETTLE);
        $display("Run covered %0d input words and %0d segment words over %0d max_workers writes,",
                 words_sent, results_seen, cfg_writes);
        $display("including empty lengths, saturated requests and a %0d-cycle output hold.",
                 LONG_HOLD);
        if (mismatches == 0) begin
            $display("tb_byte_range_segment_splitter_unit: clean");
        end else begin
            $display("tb_byte_range_segment_splitter_unit: errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/brss_pkg.sv
src/brss_divider.sv
src/brss_emitter.sv
src/byte_range_segment_splitter_unit.sv
tb/sv/tb_byte_range_segment_splitter_unit.sv
